// ===== rtl/core/y2b_pkg.sv =====
// Shared types, constants and helpers for the YUYV to BGR converter.
// Has no dependencies; every other file in rtl/core refers to it by scoped names.
package y2b_pkg;

  // Upper bound on line width and frame height.
  localparam int MAX_DIMENSION = 4096;

  // Configuration register file.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  FRAME_WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0]  FRAME_HEIGHT_RESET = 13'd1080;

  // Integer BT.601 studio-range coefficients, in the width of the channel sum.
  localparam int SUM_W = 20;
  localparam logic signed [SUM_W-1:0] COEF_Y       = 20'sd298;
  localparam logic signed [SUM_W-1:0] COEF_R_V     = 20'sd409;
  localparam logic signed [SUM_W-1:0] COEF_G_U     = 20'sd100;
  localparam logic signed [SUM_W-1:0] COEF_G_V     = 20'sd208;
  localparam logic signed [SUM_W-1:0] COEF_B_U     = 20'sd516;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 20'sd128;
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = 20'sd16;
  localparam logic signed [SUM_W-1:0] ROUND_HALF    = 20'sd128;
  localparam logic signed [SUM_W-9:0] CHANNEL_MAX   = 12'sd255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic       second_valid;
    logic       line_end;
    logic       frame_end;
  } bgr_t;

  typedef struct packed {
    logic second_valid;
    logic line_end;
    logic frame_end;
  } pos_flags_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_pixel_t;

  // Floor shift by 8 followed by a clamp to 0..255. Dropping the low eight bits of a
  // two's complement sum is the floor shift.
  function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-9:0] q;
    logic [7:0] res;
    q = sum[SUM_W-1:8];
    if (q < 0) begin
      res = 8'd0;
    end else if (q > CHANNEL_MAX) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/y2b_pixel_convert.sv =====
// Converts one luma sample and the shared chroma pair to a clamped BGR pixel.
// Depends on y2b_pkg for coefficients and the clamp helper.
module y2b_pixel_convert (
  input  logic [7:0]              luma,
  input  logic [7:0]              chroma_blue,
  input  logic [7:0]              chroma_red,
  output y2b_pkg::bgr_pixel_t     pixel
);

  logic signed [y2b_pkg::SUM_W-1:0] c;
  logic signed [y2b_pkg::SUM_W-1:0] d;
  logic signed [y2b_pkg::SUM_W-1:0] e;
  logic signed [y2b_pkg::SUM_W-1:0] luma_term;
  logic signed [y2b_pkg::SUM_W-1:0] sum_blue;
  logic signed [y2b_pkg::SUM_W-1:0] sum_green;
  logic signed [y2b_pkg::SUM_W-1:0] sum_red;

  always_comb begin
    c = $signed({12'd0, luma}) - y2b_pkg::LUMA_OFFSET;
    d = $signed({12'd0, chroma_blue}) - y2b_pkg::CHROMA_OFFSET;
    e = $signed({12'd0, chroma_red}) - y2b_pkg::CHROMA_OFFSET;
    luma_term = c * y2b_pkg::COEF_Y + y2b_pkg::ROUND_HALF;
    sum_blue  = luma_term + d * y2b_pkg::COEF_B_U;
    sum_green = luma_term - d * y2b_pkg::COEF_G_U - e * y2b_pkg::COEF_G_V;
    sum_red   = luma_term + e * y2b_pkg::COEF_R_V;
    pixel.blue  = y2b_pkg::clamp_channel(sum_blue);
    pixel.green = y2b_pkg::clamp_channel(sum_green);
    pixel.red   = y2b_pkg::clamp_channel(sum_red);
  end

endmodule

// ===== rtl/core/y2b_frame_counter.sv =====
// Column and row counters that walk the frame and derive the position flags.
// Depends on y2b_pkg for the flag struct and register width.
module y2b_frame_counter #(
  parameter int MaxDimension = y2b_pkg::MAX_DIMENSION
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [y2b_pkg::CFG_DATA_W-1:0]    frame_width,
  input  logic [y2b_pkg::CFG_DATA_W-1:0]    frame_height,
  output y2b_pkg::pos_flags_t               flags
);

  localparam int CW   = (MaxDimension > 2) ? $clog2(MaxDimension) : 1;
  localparam int DIMW = $clog2(MaxDimension + 1);
  localparam int LW   = (DIMW > y2b_pkg::CFG_DATA_W) ? DIMW : y2b_pkg::CFG_DATA_W;
  localparam int XW   = LW + 1;

  logic [CW-1:0] column_position;
  logic [CW-1:0] row_position;
  logic [CW-1:0] column_position_next;
  logic [CW-1:0] row_position_next;
  logic [LW-1:0] width_raw;
  logic [LW-1:0] height_raw;
  logic [LW-1:0] width_lim;
  logic [LW-1:0] height_lim;
  logic [XW-1:0] col_ext;
  logic [XW-1:0] row_ext;

  // Zero is taken as one and anything above the maximum saturates.
  always_comb begin
    width_raw  = LW'(frame_width);
    height_raw = LW'(frame_height);
    if (width_raw == '0) begin
      width_lim = LW'(1);
    end else if (width_raw > LW'(MaxDimension)) begin
      width_lim = LW'(MaxDimension);
    end else begin
      width_lim = width_raw;
    end
    if (height_raw == '0) begin
      height_lim = LW'(1);
    end else if (height_raw > LW'(MaxDimension)) begin
      height_lim = LW'(MaxDimension);
    end else begin
      height_lim = height_raw;
    end
  end

  always_comb begin
    col_ext = XW'(column_position);
    row_ext = XW'(row_position);
    flags.second_valid = (col_ext + XW'(1)) < XW'(width_lim);
    flags.line_end     = (col_ext + XW'(2)) >= XW'(width_lim);
    flags.frame_end    = flags.line_end && ((row_ext + XW'(1)) >= XW'(height_lim));
  end

  always_comb begin
    column_position_next = column_position;
    row_position_next    = row_position;
    if (flags.line_end) begin
      column_position_next = '0;
      row_position_next    = flags.frame_end ? '0 : CW'(row_ext + XW'(1));
    end else begin
      column_position_next = CW'(col_ext + XW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (advance) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

endmodule

// ===== rtl/core/yuyv_to_bgr_pixel_converter.sv =====
// YUYV macropixel to BGR pixel pair converter, integer BT.601 studio range.
// An accepted request waits in the input register, then moves to the output register.
// Throughput: one macropixel per cycle if bgr_stall is low; both registers sustain it.
// Reset (rst, synchronous) clears both valid stages and the frame counters, and loads
// a frame width of 1920 and a frame height of 1080.
// Depends on y2b_pkg, y2b_frame_counter and y2b_pixel_convert.
module yuyv_to_bgr_pixel_converter #(
  parameter int MaxDimension = y2b_pkg::MAX_DIMENSION
) (
  input  logic                              clk,
  input  logic                              rst,
  // Macropixel request channel.
  input  logic                              yuyv_valid,
  output logic                              yuyv_stall,
  input  y2b_pkg::yuyv_t                    yuyv,
  // BGR pixel pair channel.
  output logic                              bgr_valid,
  input  logic                              bgr_stall,
  output y2b_pkg::bgr_t                     bgr,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [y2b_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [y2b_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [y2b_pkg::CFG_DATA_W-1:0] frame_width;
  logic [y2b_pkg::CFG_DATA_W-1:0] frame_height;

  logic                  in_load;
  logic                  out_load;
  logic                  s1_valid;
  y2b_pkg::yuyv_t        s1_pix;
  y2b_pkg::pos_flags_t   s1_flags;
  y2b_pkg::pos_flags_t   pos_flags;
  y2b_pkg::bgr_pixel_t   pixel_first;
  y2b_pkg::bgr_pixel_t   pixel_second;

  // Configuration writes are always taken; the register file is two entries.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= y2b_pkg::FRAME_WIDTH_RESET;
      frame_height <= y2b_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        y2b_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
        end
        y2b_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // The output register loads whenever it is empty or its result is being taken,
  // and the input register loads whenever it is empty or moves on to the output.
  // So one request can enter while a finished result still waits downstream.
  assign out_load   = s1_valid && (!bgr_valid || !bgr_stall);
  assign yuyv_stall = s1_valid && !out_load;
  assign in_load    = yuyv_valid && !yuyv_stall;

  // The position flags belong to the counter value at acceptance, and the
  // counters step once per accepted request.
  y2b_frame_counter #(
    .MaxDimension(MaxDimension)
  ) u_frame_counter (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_load),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .flags        (pos_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_load) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_pix   <= yuyv;
      s1_flags <= pos_flags;
    end
  end

  // Both pixels share the chroma pair; the second pixel is converted even when
  // it lies past the end of the line.
  y2b_pixel_convert u_convert_first (
    .luma        (s1_pix.luma_first),
    .chroma_blue (s1_pix.chroma_blue),
    .chroma_red  (s1_pix.chroma_red),
    .pixel       (pixel_first)
  );

  y2b_pixel_convert u_convert_second (
    .luma        (s1_pix.luma_second),
    .chroma_blue (s1_pix.chroma_blue),
    .chroma_red  (s1_pix.chroma_red),
    .pixel       (pixel_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bgr_valid <= 1'b0;
    end else if (out_load) begin
      bgr_valid <= 1'b1;
    end else if (!bgr_stall) begin
      bgr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bgr.blue_first   <= pixel_first.blue;
      bgr.green_first  <= pixel_first.green;
      bgr.red_first    <= pixel_first.red;
      bgr.blue_second  <= pixel_second.blue;
      bgr.green_second <= pixel_second.green;
      bgr.red_second   <= pixel_second.red;
      bgr.second_valid <= s1_flags.second_valid;
      bgr.line_end     <= s1_flags.line_end;
      bgr.frame_end    <= s1_flags.frame_end;
    end
  end

endmodule
